// File: rtl/mmwl_pkg.sv
// Shared types and constants of the motor maneuver unit with soft position limits.
// Depends on nothing; every other file of the block uses it.
package mmwl_pkg;

	localparam int PWR_W     = 8;
	localparam int TMO_W     = 16;
	localparam int ELAPSED_W = 17;
	localparam int FUNC_W    = 3;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

	typedef logic signed [PWR_W-1:0] power_t;
	typedef logic [TMO_W-1:0]        tmo_t;
	typedef logic [ELAPSED_W-1:0]    elapsed_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK  = 3'd0,
		FUNC_START = 3'd1,
		FUNC_STOP  = 3'd2,
		FUNC_SET   = 3'd3,
		FUNC_MOVE  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		REG_MIN_EN  = 3'd0,
		REG_MAX_EN  = 3'd1,
		REG_MIN_POS = 3'd2,
		REG_MAX_POS = 3'd3,
		REG_PWR_MAX = 3'd4,
		REG_PWR_DEF = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic   min_en;
		logic   max_en;
		power_t power_max;
		power_t power_default;
	} limits_t;

endpackage

// File: rtl/mmwl_cmd_if.sv
// Command channel of the motor maneuver unit: valid/ready handshake and one input item.
// Depends on mmwl_pkg.
interface mmwl_cmd_if #(
	parameter int POS_WIDTH = 24
) ();
	logic                            valid;
	logic                            ready;
	logic [mmwl_pkg::FUNC_W-1:0]     func;
	logic signed [POS_WIDTH-1:0]     position;
	logic signed [POS_WIDTH-1:0]     target;
	mmwl_pkg::power_t                power;
	mmwl_pkg::power_t                end_power;
	mmwl_pkg::tmo_t                  timeout_ms;
	logic                            override_limits;

	modport source (
		output valid, func, position, target, power, end_power, timeout_ms,
			override_limits,
		input  ready
	);

	modport sink (
		input  valid, func, position, target, power, end_power, timeout_ms,
			override_limits,
		output ready
	);
endinterface

// File: rtl/mmwl_rsp_if.sv
// Result channel of the motor maneuver unit: valid/ready handshake and one result item.
// Depends on mmwl_pkg.
interface mmwl_rsp_if ();
	logic             valid;
	logic             ready;
	mmwl_pkg::power_t drive_power;
	logic             drive_written;
	logic             maneuver_active;

	modport source (
		output valid, drive_power, drive_written, maneuver_active,
		input  ready
	);

	modport sink (
		input  valid, drive_power, drive_written, maneuver_active,
		output ready
	);
endinterface

// File: rtl/mmwl_cfg.sv
// APB-style register file holding the soft-limit settings.
// Depends on mmwl_pkg.
module mmwl_cfg #(
	parameter int POS_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mmwl_pkg::ADDR_W-1:0]   paddr,
	input  logic [mmwl_pkg::DATA_W-1:0]   pwdata,
	output logic [mmwl_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output mmwl_pkg::limits_t             limits,
	output logic signed [POS_WIDTH-1:0]   min_pos,
	output logic signed [POS_WIDTH-1:0]   max_pos
);
	logic                        min_en_q;
	logic                        max_en_q;
	logic signed [POS_WIDTH-1:0] min_pos_q;
	logic signed [POS_WIDTH-1:0] max_pos_q;
	mmwl_pkg::power_t            power_max_q;
	mmwl_pkg::power_t            power_default_q;
	mmwl_pkg::reg_idx_t          idx;
	logic                        wr_en;

	assign idx    = mmwl_pkg::reg_idx_t'(paddr[mmwl_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_en_q        <= 1'b0;
			max_en_q        <= 1'b0;
			min_pos_q       <= '0;
			max_pos_q       <= '0;
			power_max_q     <= '0;
			power_default_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				mmwl_pkg::REG_MIN_EN:  min_en_q        <= pwdata[0];
				mmwl_pkg::REG_MAX_EN:  max_en_q        <= pwdata[0];
				mmwl_pkg::REG_MIN_POS: min_pos_q       <= pwdata[POS_WIDTH-1:0];
				mmwl_pkg::REG_MAX_POS: max_pos_q       <= pwdata[POS_WIDTH-1:0];
				mmwl_pkg::REG_PWR_MAX: power_max_q     <= pwdata[mmwl_pkg::PWR_W-1:0];
				mmwl_pkg::REG_PWR_DEF: power_default_q <= pwdata[mmwl_pkg::PWR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mmwl_pkg::REG_MIN_EN:  prdata = mmwl_pkg::DATA_W'(min_en_q);
			mmwl_pkg::REG_MAX_EN:  prdata = mmwl_pkg::DATA_W'(max_en_q);
			mmwl_pkg::REG_MIN_POS: prdata = mmwl_pkg::DATA_W'(min_pos_q);
			mmwl_pkg::REG_MAX_POS: prdata = mmwl_pkg::DATA_W'(max_pos_q);
			mmwl_pkg::REG_PWR_MAX: prdata = mmwl_pkg::DATA_W'(power_max_q);
			mmwl_pkg::REG_PWR_DEF: prdata = mmwl_pkg::DATA_W'(power_default_q);
			default:               prdata = '0;
		endcase
	end

	assign limits.min_en        = min_en_q;
	assign limits.max_en        = max_en_q;
	assign limits.power_max     = power_max_q;
	assign limits.power_default = power_default_q;
	assign min_pos              = min_pos_q;
	assign max_pos              = max_pos_q;

endmodule

// File: rtl/mmwl_clamp.sv
// Soft-limit clamp applied to each drive value before it reaches the motor, unless bypass is set.
// Depends on mmwl_pkg.
module mmwl_clamp #(
	parameter int POS_WIDTH = 24
) (
	input  mmwl_pkg::limits_t           limits,
	input  logic signed [POS_WIDTH-1:0] min_pos,
	input  logic signed [POS_WIDTH-1:0] max_pos,
	input  logic signed [POS_WIDTH-1:0] position,
	input  mmwl_pkg::power_t            power_in,
	input  logic                        bypass,
	output mmwl_pkg::power_t            power_out
);
	logic signed [mmwl_pkg::PWR_W+1:0] max_wide;
	logic signed [mmwl_pkg::PWR_W+1:0] neg_max;
	logic signed [mmwl_pkg::PWR_W+1:0] in_wide;
	mmwl_pkg::power_t                  neg_default;
	mmwl_pkg::power_t                  after_min;
	logic                              below;
	logic                              above;

	assign max_wide = (mmwl_pkg::PWR_W+2)'(limits.power_max);
	assign neg_max  = -max_wide;
	assign in_wide  = (mmwl_pkg::PWR_W+2)'(power_in);

	// Negating the most negative power saturates to the most positive one.
	assign neg_default = (limits.power_default == {1'b1, {(mmwl_pkg::PWR_W-1){1'b0}}})
		? {1'b0, {(mmwl_pkg::PWR_W-1){1'b1}}} : -limits.power_default;

	assign below     = limits.min_en && (position <= min_pos) && (in_wide < neg_max);
	assign after_min = below ? neg_default : power_in;
	assign above     = limits.max_en && (position >= max_pos) && (after_min > limits.power_max);

	assign power_out = bypass ? power_in : (above ? limits.power_default : after_min);

endmodule

// File: rtl/mmwl_ctrl.sv
// Maneuver state and the per-item decision of which drive value to apply.
// Depends on mmwl_pkg and mmwl_clamp.
module mmwl_ctrl #(
	parameter int POS_WIDTH = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [mmwl_pkg::FUNC_W-1:0] func,
	input  logic signed [POS_WIDTH-1:0] position,
	input  logic signed [POS_WIDTH-1:0] target,
	input  mmwl_pkg::power_t            power,
	input  mmwl_pkg::power_t            end_power,
	input  mmwl_pkg::tmo_t              timeout_ms,
	input  logic                        override_limits,
	input  mmwl_pkg::limits_t           limits,
	input  logic signed [POS_WIDTH-1:0] min_pos,
	input  logic signed [POS_WIDTH-1:0] max_pos,
	output mmwl_pkg::power_t            drive_power,
	output logic                        drive_written,
	output logic                        maneuver_active
);
	logic                        active_q;
	logic                        going_up_q;
	logic signed [POS_WIDTH-1:0] goal_q;
	mmwl_pkg::power_t            run_power_q;
	mmwl_pkg::power_t            finish_power_q;
	mmwl_pkg::tmo_t              time_limit_q;
	mmwl_pkg::elapsed_t          elapsed_q;
	mmwl_pkg::power_t            current_drive_q;

	logic                        active_d;
	logic                        going_up_d;
	logic signed [POS_WIDTH-1:0] goal_d;
	mmwl_pkg::power_t            run_power_d;
	mmwl_pkg::power_t            finish_power_d;
	mmwl_pkg::tmo_t              time_limit_d;
	mmwl_pkg::elapsed_t          elapsed_d;
	mmwl_pkg::power_t            current_drive_d;

	mmwl_pkg::power_t            mag;
	mmwl_pkg::elapsed_t          elapsed_inc;
	mmwl_pkg::power_t            drv_req;
	mmwl_pkg::power_t            drv_clamped;
	logic                        bypass;
	logic                        written;
	logic                        up;

	// Magnitude of the commanded power, with the most negative value saturated.
	assign mag = (power == {1'b1, {(mmwl_pkg::PWR_W-1){1'b0}}})
		? {1'b0, {(mmwl_pkg::PWR_W-1){1'b1}}}
		: (power[mmwl_pkg::PWR_W-1] ? -power : power);

	assign elapsed_inc = (elapsed_q == mmwl_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign up          = target > position;

	always_comb begin
		active_d       = active_q;
		going_up_d     = going_up_q;
		goal_d         = goal_q;
		run_power_d    = run_power_q;
		finish_power_d = finish_power_q;
		time_limit_d   = time_limit_q;
		elapsed_d      = elapsed_q;
		drv_req        = '0;
		bypass         = 1'b0;
		written        = 1'b0;
		case (func)
			mmwl_pkg::FUNC_TICK: begin
				if (active_q) begin
					if (going_up_q == (position < goal_q)) begin
						elapsed_d = '0;
						drv_req   = run_power_q;
						written   = 1'b1;
					end else begin
						elapsed_d = elapsed_inc;
						if (elapsed_inc > mmwl_pkg::ELAPSED_W'(time_limit_q)) begin
							active_d = 1'b0;
							drv_req  = finish_power_q;
							written  = 1'b1;
						end
					end
				end
			end
			mmwl_pkg::FUNC_START: begin
				goal_d         = target;
				finish_power_d = end_power;
				going_up_d     = up;
				run_power_d    = up ? mag : -mag;
				active_d       = 1'b1;
				time_limit_d   = timeout_ms;
				elapsed_d      = '0;
			end
			mmwl_pkg::FUNC_STOP: begin
				active_d = 1'b0;
				written  = 1'b1;
			end
			mmwl_pkg::FUNC_SET: begin
				drv_req = power;
				bypass  = override_limits;
				written = 1'b1;
			end
			mmwl_pkg::FUNC_MOVE: begin
				drv_req = (target < position) ? -mag : mag;
				written = 1'b1;
			end
			default: ;
		endcase
	end

	mmwl_clamp #(
		.POS_WIDTH(POS_WIDTH)
	) u_clamp (
		.limits   (limits),
		.min_pos  (min_pos),
		.max_pos  (max_pos),
		.position (position),
		.power_in (drv_req),
		.bypass   (bypass),
		.power_out(drv_clamped)
	);

	assign current_drive_d = written ? drv_clamped : current_drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q        <= 1'b0;
			going_up_q      <= 1'b0;
			goal_q          <= '0;
			run_power_q     <= '0;
			finish_power_q  <= '0;
			time_limit_q    <= '0;
			elapsed_q       <= '0;
			current_drive_q <= '0;
		end else if (step) begin
			active_q        <= active_d;
			going_up_q      <= going_up_d;
			goal_q          <= goal_d;
			run_power_q     <= run_power_d;
			finish_power_q  <= finish_power_d;
			time_limit_q    <= time_limit_d;
			elapsed_q       <= elapsed_d;
			current_drive_q <= current_drive_d;
		end
	end

	assign drive_power     = current_drive_d;
	assign drive_written   = written;
	assign maneuver_active = active_d;

endmodule

// File: rtl/motor_maneuver_with_limits_unit.sv
// Top level of the motor maneuver unit with soft position limits.
// Depends on mmwl_pkg, mmwl_cmd_if, mmwl_rsp_if, mmwl_cfg and mmwl_ctrl.
//
// The unit takes one command or tick per clock cycle unless the result channel stalls,
// and returns exactly one result for each. A command is registered in the input
// register when it is transferred and evaluated there against the maneuver state,
// and its outcome is written to the result register, from which its result is offered.
// The input register and the result register form a two-entry pipeline: a new
// command is taken while a result waits, and the command channel stalls only when both
// are full. Soft limits are set through the APB-style port at byte addresses 0 to 20
// and are meant to be changed while no command is in flight.
module motor_maneuver_with_limits_unit #(
	parameter int POS_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mmwl_cmd_if.sink                      cmd,
	mmwl_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mmwl_pkg::ADDR_W-1:0]   paddr,
	input  logic [mmwl_pkg::DATA_W-1:0]   pwdata,
	output logic [mmwl_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	logic                        valid_s1;
	logic [mmwl_pkg::FUNC_W-1:0] func_s1;
	logic signed [POS_WIDTH-1:0] position_s1;
	logic signed [POS_WIDTH-1:0] target_s1;
	mmwl_pkg::power_t            power_s1;
	mmwl_pkg::power_t            end_power_s1;
	mmwl_pkg::tmo_t              timeout_ms_s1;
	logic                        override_limits_s1;

	logic                        rsp_valid_q;
	mmwl_pkg::power_t            drive_power_q;
	logic                        drive_written_q;
	logic                        maneuver_active_q;

	mmwl_pkg::limits_t           limits;
	logic signed [POS_WIDTH-1:0] min_pos;
	logic signed [POS_WIDTH-1:0] max_pos;
	mmwl_pkg::power_t            drive_power_c;
	logic                        drive_written_c;
	logic                        maneuver_active_c;
	logic                        advance;
	logic                        cmd_ready;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd_ready = !valid_s1 || advance;
	assign cmd.ready = cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd.valid) begin
			func_s1            <= cmd.func;
			position_s1        <= cmd.position;
			target_s1          <= cmd.target;
			power_s1           <= cmd.power;
			end_power_s1       <= cmd.end_power;
			timeout_ms_s1      <= cmd.timeout_ms;
			override_limits_s1 <= cmd.override_limits;
		end
	end

	mmwl_cfg #(
		.POS_WIDTH(POS_WIDTH)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.limits (limits),
		.min_pos(min_pos),
		.max_pos(max_pos)
	);

	mmwl_ctrl #(
		.POS_WIDTH(POS_WIDTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.func           (func_s1),
		.position       (position_s1),
		.target         (target_s1),
		.power          (power_s1),
		.end_power      (end_power_s1),
		.timeout_ms     (timeout_ms_s1),
		.override_limits(override_limits_s1),
		.limits         (limits),
		.min_pos        (min_pos),
		.max_pos        (max_pos),
		.drive_power    (drive_power_c),
		.drive_written  (drive_written_c),
		.maneuver_active(maneuver_active_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_power_q     <= drive_power_c;
			drive_written_q   <= drive_written_c;
			maneuver_active_q <= maneuver_active_c;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.drive_power     = drive_power_q;
	assign rsp.drive_written   = drive_written_q;
	assign rsp.maneuver_active = maneuver_active_q;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench of motor_maneuver_with_limits_unit: directed and random commands and ticks,
// checked one result at a time against a maneuver and soft-limit predictor held here.
// Depends on mmwl_pkg, mmwl_cmd_if, mmwl_rsp_if and the unit itself.
module tb;
	import mmwl_pkg::*;

	localparam int POS_W = 24;
	localparam int POS_MIN = -(1 << (POS_W - 1));
	localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
	localparam int QUIET_LIMIT = 2000;
	localparam int PRINT_LIMIT = 200;
	localparam logic [2:0] REG_UNMAPPED = 3'd6;
	localparam int FUNC_FIRST_SPARE = 5;

	typedef logic signed [POS_W-1:0] pos_t;

	typedef struct {
		logic [FUNC_W-1:0] func;
		pos_t              position;
		pos_t              target;
		power_t            power;
		power_t            end_power;
		tmo_t              timeout_ms;
		logic              override_limits;
	} motor_cmd_t;

	typedef struct {
		power_t drive_power;
		logic   drive_written;
		logic   maneuver_active;
	} drive_result_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	mmwl_cmd_if #(.POS_WIDTH(POS_W)) cmd_ch ();
	mmwl_rsp_if rsp_ch ();

	motor_maneuver_with_limits_unit #(.POS_WIDTH(POS_W)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	limits_t  lim = '0;
	pos_t     lim_min_pos = '0;
	pos_t     lim_max_pos = '0;
	bit       mv_active = 1'b0;
	bit       mv_going_up = 1'b0;
	pos_t     mv_goal = '0;
	power_t   mv_run_power = '0;
	power_t   mv_finish_power = '0;
	tmo_t     mv_time_limit = '0;
	elapsed_t mv_elapsed = '0;
	power_t   held_drive = '0;

	drive_result_t pending_drive_q[$];
	int mismatches = 0;
	int items_sent = 0;
	bit tx_gaps = 1'b0;
	bit rx_stalls = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int sat_power(int v);
		if (v > 127) return 127;
		if (v < -128) return -128;
		return v;
	endfunction

	function automatic int power_magnitude(int v);
		return sat_power(v < 0 ? -v : v);
	endfunction

	function automatic void drive_clamped(int p, bit bypass, int pos);
		if (!bypass) begin
			if (lim.min_en && pos <= int'(lim_min_pos) && p < -int'($signed(lim.power_max)))
				p = sat_power(-int'($signed(lim.power_default)));
			if (lim.max_en && pos >= int'(lim_max_pos) && p > int'($signed(lim.power_max)))
				p = int'($signed(lim.power_default));
		end
		held_drive = power_t'(sat_power(p));
	endfunction

	function automatic drive_result_t predict_drive(motor_cmd_t c);
		drive_result_t r;
		int pos;
		int tgt;
		int pw;
		pos = int'(c.position);
		tgt = int'(c.target);
		pw = int'(c.power);
		r.drive_written = 1'b0;
		case (c.func)
			FUNC_TICK: begin
				if (mv_active) begin
					if (mv_going_up == (pos < int'(mv_goal))) begin
						mv_elapsed = '0;
						drive_clamped(int'(mv_run_power), 1'b0, pos);
						r.drive_written = 1'b1;
					end else begin
						if (mv_elapsed != ELAPSED_MAX)
							mv_elapsed++;
						if (mv_elapsed > mv_time_limit) begin
							mv_active = 1'b0;
							drive_clamped(int'(mv_finish_power), 1'b0, pos);
							r.drive_written = 1'b1;
						end
					end
				end
			end
			FUNC_START: begin
				mv_goal = c.target;
				mv_finish_power = c.end_power;
				mv_going_up = tgt > pos;
				mv_run_power = power_t'(mv_going_up ? power_magnitude(pw) : -power_magnitude(pw));
				mv_active = 1'b1;
				mv_time_limit = c.timeout_ms;
				mv_elapsed = '0;
			end
			FUNC_STOP: begin
				mv_active = 1'b0;
				drive_clamped(0, 1'b0, pos);
				r.drive_written = 1'b1;
			end
			FUNC_SET: begin
				drive_clamped(pw, c.override_limits, pos);
				r.drive_written = 1'b1;
			end
			FUNC_MOVE: begin
				drive_clamped(tgt < pos ? -power_magnitude(pw) : power_magnitude(pw), 1'b0, pos);
				r.drive_written = 1'b1;
			end
			default: begin
			end
		endcase
		r.drive_power = held_drive;
		r.maneuver_active = mv_active;
		return r;
	endfunction

	function automatic void note_limit_write(logic [2:0] idx, logic [DATA_W-1:0] value);
		case (idx)
			REG_MIN_EN:  lim.min_en = value[0];
			REG_MAX_EN:  lim.max_en = value[0];
			REG_MIN_POS: lim_min_pos = value[POS_W-1:0];
			REG_MAX_POS: lim_max_pos = value[POS_W-1:0];
			REG_PWR_MAX: lim.power_max = value[PWR_W-1:0];
			REG_PWR_DEF: lim.power_default = value[PWR_W-1:0];
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin : scoreboard
		motor_cmd_t c;
		drive_result_t want;
		if (cmd_ch.valid && cmd_ch.ready) begin
			c.func = cmd_ch.func;
			c.position = cmd_ch.position;
			c.target = cmd_ch.target;
			c.power = cmd_ch.power;
			c.end_power = cmd_ch.end_power;
			c.timeout_ms = cmd_ch.timeout_ms;
			c.override_limits = cmd_ch.override_limits;
			pending_drive_q.push_back(predict_drive(c));
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_drive_q.size() == 0) begin
				report_mismatch("result transfer with no command outstanding");
			end else begin
				want = pending_drive_q.pop_front();
				if (rsp_ch.drive_power !== want.drive_power)
					report_mismatch($sformatf("drive_power %0d, expected %0d",
						rsp_ch.drive_power, want.drive_power));
				if (rsp_ch.drive_written !== want.drive_written)
					report_mismatch($sformatf("drive_written %b, expected %b",
						rsp_ch.drive_written, want.drive_written));
				if (rsp_ch.maneuver_active !== want.maneuver_active)
					report_mismatch($sformatf("maneuver_active %b, expected %b",
						rsp_ch.maneuver_active, want.maneuver_active));
			end
		end
		if (psel && penable && pwrite && pready)
			note_limit_write(paddr[ADDR_W-1:2], pwdata);
	end

	initial begin : result_sink
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_stalls && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("motor_maneuver_with_limits_unit regression: fail");
		$finish;
	end

	task automatic send_cmd(motor_cmd_t c);
		cmd_ch.func <= c.func;
		cmd_ch.position <= c.position;
		cmd_ch.target <= c.target;
		cmd_ch.power <= c.power;
		cmd_ch.end_power <= c.end_power;
		cmd_ch.timeout_ms <= c.timeout_ms;
		cmd_ch.override_limits <= c.override_limits;
		cmd_ch.valid <= 1'b1;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		@(negedge clk);
		items_sent++;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	task automatic wait_for_results();
		cmd_ch.valid <= 1'b0;
		while (pending_drive_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(logic [2:0] idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic apply_limits(bit min_en, bit max_en, int min_pos, int max_pos,
			int pwr_max, int pwr_def);
		wait_for_results();
		write_limit(REG_UNMAPPED, $urandom);
		write_limit(REG_MIN_EN, 32'(min_en));
		write_limit(REG_MAX_EN, 32'(max_en));
		write_limit(REG_MIN_POS, 32'(min_pos));
		write_limit(REG_MAX_POS, 32'(max_pos));
		write_limit(REG_PWR_MAX, 32'(pwr_max));
		write_limit(REG_PWR_DEF, 32'(pwr_def));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	function automatic pos_t clip_pos(int v);
		if (v > POS_MAX) return pos_t'(POS_MAX);
		if (v < POS_MIN) return pos_t'(POS_MIN);
		return pos_t'(v);
	endfunction

	function automatic pos_t near_pos(int center, int spread);
		return clip_pos(center + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	function automatic power_t random_power();
		return power_t'(int'($urandom_range(0, 254)) - 127);
	endfunction

	function automatic motor_cmd_t random_cmd();
		motor_cmd_t c;
		c.func = FUNC_W'($urandom_range(FUNC_TICK, FUNC_MOVE));
		c.position = pos_t'($urandom);
		c.target = pos_t'($urandom);
		c.power = random_power();
		c.end_power = random_power();
		c.timeout_ms = tmo_t'($urandom);
		c.override_limits = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic motor_cmd_t make_cmd(logic [FUNC_W-1:0] func, int position, int target,
			int power);
		motor_cmd_t c;
		c.func = func;
		c.position = pos_t'(position);
		c.target = pos_t'(target);
		c.power = power_t'(power);
		c.end_power = '0;
		c.timeout_ms = '0;
		c.override_limits = 1'b0;
		return c;
	endfunction

	task automatic test_basic_commands();
		motor_cmd_t c;
		send_cmd(make_cmd(FUNC_TICK, 0, 0, 0));
		send_cmd(make_cmd(FUNC_SET, 0, 0, 127));
		c = make_cmd(FUNC_SET, 0, 0, -127);
		c.override_limits = 1'b1;
		send_cmd(c);
		send_cmd(make_cmd(FUNC_MOVE, POS_MIN, POS_MAX, -100));
		send_cmd(make_cmd(FUNC_MOVE, POS_MAX, POS_MIN, 90));
		send_cmd(make_cmd(FUNC_MOVE, 5, 5, -3));
		for (int f = FUNC_FIRST_SPARE; f < 2 ** FUNC_W; f++)
			send_cmd(make_cmd(f[FUNC_W-1:0], 0, 0, 50));
		// Upward run that ends once the target has been passed longer than the timeout.
		c = make_cmd(FUNC_START, 0, 10, -60);
		c.end_power = -20;
		c.timeout_ms = 1;
		send_cmd(c);
		send_cmd(make_cmd(FUNC_TICK, 3, 0, 0));
		send_cmd(make_cmd(FUNC_TICK, 10, 0, 0));
		send_cmd(make_cmd(FUNC_TICK, 12, 0, 0));
		send_cmd(make_cmd(FUNC_TICK, 0, 0, 0));
		// Starting on the target counts as a downward run, here cut short by a stop.
		c = make_cmd(FUNC_START, 100, 100, 127);
		c.end_power = 85;
		c.timeout_ms = '1;
		send_cmd(c);
		send_cmd(make_cmd(FUNC_TICK, 100, 0, 0));
		send_cmd(make_cmd(FUNC_STOP, 0, 0, 0));
		c = make_cmd(FUNC_START, POS_MIN, POS_MAX, -128);
		c.end_power = 127;
		send_cmd(c);
		send_cmd(make_cmd(FUNC_TICK, POS_MAX, 0, 0));
	endtask

	task automatic test_soft_limits();
		motor_cmd_t c;
		apply_limits(1'b1, 1'b1, -100, 100, 50, 20);
		send_cmd(make_cmd(FUNC_SET, 100, 0, 100));
		c = make_cmd(FUNC_SET, 100, 0, 100);
		c.override_limits = 1'b1;
		send_cmd(c);
		send_cmd(make_cmd(FUNC_SET, -100, 0, -100));
		send_cmd(make_cmd(FUNC_SET, -99, 0, -100));
		send_cmd(make_cmd(FUNC_SET, 200, 0, 50));
		send_cmd(make_cmd(FUNC_MOVE, 150, 500, -80));
		send_cmd(make_cmd(FUNC_STOP, 200, 0, 0));
		send_cmd(make_cmd(FUNC_START, 90, 120, 70));
		send_cmd(make_cmd(FUNC_TICK, 100, 0, 0));
	endtask

	task automatic run_random_traffic(int n, bit allow_idle);
		int stop_at;
		int center;
		int pos;
		int goal;
		int step;
		bit upward;
		motor_cmd_t c;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			tx_gaps = allow_idle && $urandom_range(0, 2) != 0;
			rx_stalls = allow_idle && $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 9) < 2) begin
				send_cmd(random_cmd());
			end else begin
				// A maneuver near one of the soft limits, followed by ticks that walk the
				// position through the target, with the odd other command mixed in.
				center = $urandom_range(0, 1) ? int'(lim_min_pos) : int'(lim_max_pos);
				pos = int'(near_pos(center, 40));
				goal = int'(near_pos(pos, 30));
				upward = goal > pos;
				c = random_cmd();
				c.func = FUNC_START;
				c.position = pos_t'(pos);
				c.target = pos_t'(goal);
				if ($urandom_range(0, 7) != 0)
					c.timeout_ms = tmo_t'($urandom_range(0, 4));
				send_cmd(c);
				repeat ($urandom_range(2, 12)) begin
					c = random_cmd();
					case ($urandom_range(0, 15))
						0: c.func = FUNC_STOP;
						1: c.func = FUNC_SET;
						2: c.func = FUNC_MOVE;
						default: c.func = FUNC_TICK;
					endcase
					step = $urandom_range(0, 12);
					if (upward != ($urandom_range(0, 4) == 0))
						pos = int'(clip_pos(pos + step));
					else
						pos = int'(clip_pos(pos - step));
					c.position = pos_t'(pos);
					send_cmd(c);
				end
			end
		end
	endtask

	task automatic test_limit_extremes();
		apply_limits(1'b1, 1'b1, POS_MIN, POS_MAX, 127, -127);
		run_random_traffic(100, 1'b1);
		apply_limits(1'b1, 1'b1, POS_MAX, POS_MIN, -127, 127);
		run_random_traffic(100, 1'b1);
	endtask

	task automatic random_limits();
		int base;
		int pwr_max;
		base = int'($urandom_range(0, 4000)) - 2000;
		pwr_max = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 254)) - 127
			: int'($urandom_range(0, 127));
		apply_limits(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			base - int'($urandom_range(0, 300)), base + int'($urandom_range(0, 300)),
			pwr_max, int'($urandom_range(0, 254)) - 127);
	endtask

	task automatic test_random_limits();
		repeat (6) begin
			random_limits();
			run_random_traffic(130, 1'b1);
		end
	endtask

	task automatic test_steady_stream();
		random_limits();
		run_random_traffic(150, 1'b0);
	endtask

	initial begin : run
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.func <= FUNC_TICK;
		cmd_ch.position <= '0;
		cmd_ch.target <= '0;
		cmd_ch.power <= '0;
		cmd_ch.end_power <= '0;
		cmd_ch.timeout_ms <= '0;
		cmd_ch.override_limits <= 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basic_commands();
		test_soft_limits();
		test_limit_extremes();
		test_random_limits();
		test_steady_stream();
		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("motor_maneuver_with_limits_unit regression: pass");
		else
			$display("motor_maneuver_with_limits_unit regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
rtl/mmwl_pkg.sv
rtl/mmwl_cmd_if.sv
rtl/mmwl_rsp_if.sv
rtl/mmwl_cfg.sv
rtl/mmwl_clamp.sv
rtl/mmwl_ctrl.sv
rtl/motor_maneuver_with_limits_unit.sv
bench/tb.sv
